// File: src/rlat_pkg.sv
// Shared types and constants for the reliable link acknowledgement tracker.
package rlat_pkg;

   // Default number of entries in the pending-send table.
   localparam int PENDING_DEPTH_DEF = 32;

   // Depth of the queue between the request front end and the engine.
   localparam int QUEUE_DEPTH = 2;

   // Field widths.
   localparam int PEER_W    = 48;
   localparam int SEQ_W     = 16;
   localparam int BITS_W    = 32;
   localparam int MS_W      = 16;
   localparam int SILENCE_W = 17;
   localparam int COUNT_W   = 6;
   localparam int STATE_W   = 3;

   // Stream payload widths.
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 80;

   // Saturation limits.
   localparam logic [SILENCE_W-1:0] SILENCE_MAX = 17'h1FFFF;
   localparam logic [COUNT_W-1:0]   COUNT_MAX   = 6'd63;
   localparam logic [15:0]          TIMEOUT_RESET = 16'd10000;

   // Highest history bit index.
   localparam logic [SEQ_W-1:0] HISTORY_TOP = 16'd31;

   // Configuration register indexes.
   localparam logic CSR_ROLE    = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   // Role values.
   localparam logic ROLE_SERVER = 1'b0;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_OPEN = 2'd0,
      KIND_SEND = 2'd1,
      KIND_RECV = 2'd2,
      KIND_TICK = 2'd3
   } kind_type;

   // Link states as reported to the user.
   localparam logic [STATE_W-1:0] LINK_DISCONNECTED = 3'd0;
   localparam logic [STATE_W-1:0] LINK_LISTENING    = 3'd1;
   localparam logic [STATE_W-1:0] LINK_CONNECTING   = 3'd2;
   localparam logic [STATE_W-1:0] LINK_CONNECTED    = 3'd3;
   localparam logic [STATE_W-1:0] LINK_CONNECT_FAIL = 3'd4;

   // One classified request as it travels from the front end to the engine.
   typedef struct packed {
      kind_type              kind;
      logic [PEER_W-1:0]     peer_address;
      logic [SEQ_W-1:0]      sequence_req;
      logic [SEQ_W-1:0]      ack;
      logic [BITS_W-1:0]     ack_mask;
      logic [MS_W-1:0]       elapsed_ms;
   } item_type;

endpackage

// File: src/rlat_front.sv
// Request front end: accepts stream requests, classifies them and queues them.
module rlat_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: peer_address, sequence_req, ack, ack_mask, elapsed_ms.
   input  logic [rlat_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Fields from bit 0 up: action.
   input  logic [1:0]                       req_tuser,
   output logic                             q_valid,
   output rlat_pkg::item_type               q_item,
   input  logic                             q_pop
);

   localparam int PTR_W = (rlat_pkg::QUEUE_DEPTH > 1) ? $clog2(rlat_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(rlat_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rlat_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rlat_pkg::QUEUE_DEPTH - 1);

   rlat_pkg::item_type queue_ff [rlat_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rlat_pkg::item_type new_item;
   logic push;
   logic pop;

   // Classify the incoming request.
   always_comb begin
      new_item.kind         = rlat_pkg::kind_type'(req_tuser);
      new_item.peer_address = req_tdata[47:0];
      new_item.sequence_req = req_tdata[63:48];
      new_item.ack          = req_tdata[79:64];
      new_item.ack_mask     = req_tdata[111:80];
      new_item.elapsed_ms   = req_tdata[127:112];
   end

   assign req_tready = (count_ff != FULL_CNT);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = queue_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: src/rlat_back.sv
// Link engine: connection state, receive history and the pending-send table.
module rlat_back #(
   parameter int PENDING_DEPTH = rlat_pkg::PENDING_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [15:0]                      csr_wdata,
   input  logic                             q_valid,
   input  rlat_pkg::item_type               q_item,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0 up: hdr_sequence, hdr_ack, hdr_ack_bits, acked_count,
   // accepted, table_full, link_state.
   output logic [rlat_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PENDING_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND_SCAN,
      ST_RET_SCAN,
      ST_DONE
   } eng_state_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SERVER,
      MODE_CLIENT
   } mode_type;

   // Configuration registers.
   logic        role_ff;
   logic [15:0] timeout_ff;

   // Link state.
   eng_state_type                       state_ff, state_in;
   mode_type                            mode_ff, mode_in;
   logic [rlat_pkg::STATE_W-1:0]        conn_ff, conn_in;
   logic [rlat_pkg::SILENCE_W-1:0]      silence_ff, silence_in;
   logic [rlat_pkg::PEER_W-1:0]         peer_ff, peer_in;
   logic [rlat_pkg::SEQ_W-1:0]          local_seq_ff, local_seq_in;
   logic [rlat_pkg::SEQ_W-1:0]          remote_seq_ff, remote_seq_in;
   logic                                any_rx_ff, any_rx_in;
   logic [rlat_pkg::BITS_W-1:0]         history_ff, history_in;

   // Per-request working registers.
   logic [rlat_pkg::SEQ_W-1:0]          hdr_seq_ff, hdr_seq_in;
   logic [rlat_pkg::SEQ_W-1:0]          hdr_ack_ff, hdr_ack_in;
   logic [rlat_pkg::BITS_W-1:0]         hdr_bits_ff, hdr_bits_in;
   logic [rlat_pkg::COUNT_W-1:0]        acked_ff, acked_in;
   logic                                accepted_ff, accepted_in;
   logic                                full_ff, full_in;
   logic [rlat_pkg::SEQ_W-1:0]          ack_ff, ack_in;
   logic [rlat_pkg::BITS_W-1:0]         bits_ff, bits_in;

   // Table scan.
   logic [IDX_W-1:0]                    scan_idx_ff, scan_idx_in;
   logic                                issue_ff, issue_in;
   logic                                chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]                    chk_idx_ff, chk_idx_in;
   logic [PENDING_DEPTH-1:0]            pend_valid_ff, pend_valid_in;

   // Pending sequence memory.
   logic [rlat_pkg::SEQ_W-1:0]          pend_mem [PENDING_DEPTH];
   logic [rlat_pkg::SEQ_W-1:0]          rd_data_ff;
   logic                                mem_we;

   // Result register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rlat_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // Receive and retire helpers.
   logic [rlat_pkg::SEQ_W-1:0]          rx_fwd;
   logic [rlat_pkg::SEQ_W-1:0]          rx_back;
   logic [rlat_pkg::SEQ_W-1:0]          rx_back_m1;
   logic                                rx_newer;
   logic [rlat_pkg::SEQ_W-1:0]          ret_diff;
   logic [rlat_pkg::SEQ_W-1:0]          ret_fwd;
   logic [rlat_pkg::SEQ_W-1:0]          ret_bi;
   logic                                ret_hit;
   logic [rlat_pkg::SILENCE_W:0]        tick_sum;
   logic [rlat_pkg::SILENCE_W-1:0]      tick_sat;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff    <= rlat_pkg::ROLE_SERVER;
         timeout_ff <= rlat_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rlat_pkg::CSR_ROLE:    role_ff    <= csr_wdata[0];
            rlat_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            default:               role_ff    <= role_ff;
         endcase
      end
   end

   // Sequence distance terms for a received header.
   assign rx_fwd     = q_item.sequence_req - remote_seq_ff;
   assign rx_back    = remote_seq_ff - q_item.sequence_req;
   assign rx_back_m1 = rx_back - 1'b1;
   assign rx_newer   = (rx_fwd != '0) && !rx_fwd[rlat_pkg::SEQ_W-1];

   // Acknowledge test for the pending entry read last cycle.
   assign ret_diff = ack_ff - rd_data_ff;
   assign ret_fwd  = rd_data_ff - ack_ff;
   assign ret_bi   = ret_diff - 1'b1;
   always_comb begin
      ret_hit = 1'b0;
      if (ret_diff == '0) begin
         ret_hit = 1'b1;
      end else if (!((ret_fwd != '0) && !ret_fwd[rlat_pkg::SEQ_W-1])) begin
         if (ret_bi <= rlat_pkg::HISTORY_TOP) begin
            ret_hit = bits_ff[ret_bi[4:0]];
         end
      end
   end

   // Silence accumulation on a tick.
   assign tick_sum = {1'b0, silence_ff} + {{(rlat_pkg::SILENCE_W + 1 - rlat_pkg::MS_W){1'b0}},
                                           q_item.elapsed_ms};
   assign tick_sat = tick_sum[rlat_pkg::SILENCE_W] ? rlat_pkg::SILENCE_MAX
                                                    : tick_sum[rlat_pkg::SILENCE_W-1:0];

   // Engine sequencer.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      conn_in       = conn_ff;
      silence_in    = silence_ff;
      peer_in       = peer_ff;
      local_seq_in  = local_seq_ff;
      remote_seq_in = remote_seq_ff;
      any_rx_in     = any_rx_ff;
      history_in    = history_ff;
      hdr_seq_in    = hdr_seq_ff;
      hdr_ack_in    = hdr_ack_ff;
      hdr_bits_in   = hdr_bits_ff;
      acked_in      = acked_ff;
      accepted_in   = accepted_ff;
      full_in       = full_ff;
      ack_in        = ack_ff;
      bits_in       = bits_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = 1'b0;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      q_pop         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               hdr_seq_in  = '0;
               hdr_ack_in  = '0;
               hdr_bits_in = '0;
               acked_in    = '0;
               accepted_in = 1'b0;
               full_in     = 1'b0;
               case (q_item.kind)
                  rlat_pkg::KIND_OPEN: begin
                     silence_in = '0;
                     if (role_ff == rlat_pkg::ROLE_SERVER) begin
                        mode_in = MODE_SERVER;
                        conn_in = rlat_pkg::LINK_LISTENING;
                        peer_in = '0;
                     end else begin
                        mode_in = MODE_CLIENT;
                        conn_in = rlat_pkg::LINK_CONNECTING;
                        peer_in = q_item.peer_address;
                     end
                     state_in = ST_DONE;
                  end
                  rlat_pkg::KIND_SEND: begin
                     hdr_seq_in   = local_seq_ff;
                     hdr_ack_in   = remote_seq_ff;
                     hdr_bits_in  = history_ff;
                     local_seq_in = local_seq_ff + 1'b1;
                     scan_idx_in  = '0;
                     state_in     = ST_SEND_SCAN;
                  end
                  rlat_pkg::KIND_RECV: begin
                     // Update the remote sequence and received history.
                     if (!any_rx_ff) begin
                        any_rx_in     = 1'b1;
                        remote_seq_in = q_item.sequence_req;
                        history_in    = '0;
                     end else if (rx_newer) begin
                        if (rx_fwd < 16'd32) begin
                           history_in = (history_ff << rx_fwd[4:0])
                                      | (32'd1 << (rx_fwd[4:0] - 5'd1));
                        end else if (rx_fwd == 16'd32) begin
                           history_in = 32'h8000_0000;
                        end else begin
                           history_in = '0;
                        end
                        remote_seq_in = q_item.sequence_req;
                     end else if (rx_back != '0) begin
                        if (rx_back_m1 <= rlat_pkg::HISTORY_TOP) begin
                           history_in = history_ff | (32'd1 << rx_back_m1[4:0]);
                        end
                     end
                     // Connection progress.
                     if (mode_ff == MODE_SERVER && conn_ff != rlat_pkg::LINK_CONNECTED) begin
                        conn_in = rlat_pkg::LINK_CONNECTED;
                        peer_in = q_item.peer_address;
                     end
                     if (q_item.peer_address == peer_in) begin
                        if (mode_ff == MODE_CLIENT && conn_ff == rlat_pkg::LINK_CONNECTING) begin
                           conn_in = rlat_pkg::LINK_CONNECTED;
                        end
                        silence_in  = '0;
                        accepted_in = 1'b1;
                     end
                     ack_in      = q_item.ack;
                     bits_in     = q_item.ack_mask;
                     scan_idx_in = '0;
                     issue_in    = 1'b1;
                     state_in    = ST_RET_SCAN;
                  end
                  default: begin
                     silence_in = tick_sat;
                     if (tick_sat > {1'b0, timeout_ff}) begin
                        if (conn_ff == rlat_pkg::LINK_CONNECTING) begin
                           conn_in    = rlat_pkg::LINK_CONNECT_FAIL;
                           silence_in = '0;
                           peer_in    = '0;
                        end else if (conn_ff == rlat_pkg::LINK_CONNECTED) begin
                           conn_in    = rlat_pkg::LINK_DISCONNECTED;
                           silence_in = '0;
                           peer_in    = '0;
                        end
                     end
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Look for the first free pending entry, one per cycle.
         ST_SEND_SCAN: begin
            if (!pend_valid_ff[scan_idx_ff]) begin
               mem_we                     = 1'b1;
               pend_valid_in[scan_idx_ff] = 1'b1;
               state_in                   = ST_DONE;
            end else if (scan_idx_ff == LAST_IDX) begin
               full_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         // Read one entry a cycle and test the entry read the cycle before.
         ST_RET_SCAN: begin
            if (issue_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_idx_ff;
               if (scan_idx_ff != LAST_IDX) begin
                  scan_idx_in = scan_idx_ff + 1'b1;
                  issue_in    = 1'b1;
               end
            end
            if (chk_vld_ff) begin
               if (pend_valid_ff[chk_idx_ff] && ret_hit) begin
                  pend_valid_in[chk_idx_ff] = 1'b0;
                  if (acked_ff != rlat_pkg::COUNT_MAX) begin
                     acked_in = acked_ff + 1'b1;
                  end
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, conn_ff, full_ff, accepted_ff, acked_ff,
                               hdr_bits_ff, hdr_ack_ff, hdr_seq_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and link state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_NONE;
         conn_ff       <= rlat_pkg::LINK_DISCONNECTED;
         silence_ff    <= '0;
         peer_ff       <= '0;
         local_seq_ff  <= '0;
         remote_seq_ff <= '0;
         any_rx_ff     <= 1'b0;
         history_ff    <= '0;
         issue_ff      <= 1'b0;
         chk_vld_ff    <= 1'b0;
         pend_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         conn_ff       <= conn_in;
         silence_ff    <= silence_in;
         peer_ff       <= peer_in;
         local_seq_ff  <= local_seq_in;
         remote_seq_ff <= remote_seq_in;
         any_rx_ff     <= any_rx_in;
         history_ff    <= history_in;
         issue_ff      <= issue_in;
         chk_vld_ff    <= chk_vld_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hdr_seq_ff  <= hdr_seq_in;
      hdr_ack_ff  <= hdr_ack_in;
      hdr_bits_ff <= hdr_bits_in;
      acked_ff    <= acked_in;
      accepted_ff <= accepted_in;
      full_ff     <= full_in;
      ack_ff      <= ack_in;
      bits_ff     <= bits_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Pending sequence memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pend_mem[scan_idx_ff] <= hdr_seq_ff;
      end
      rd_data_ff <= pend_mem[scan_idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A checked entry always belongs to the retire scan.
   a_chk_in_scan : assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == ST_RET_SCAN))
      else $error("table check outside retire scan");

   // The connection state never leaves its defined codes.
   a_conn_range : assert property (@(posedge clock) disable iff (reset)
      conn_ff <= rlat_pkg::LINK_CONNECT_FAIL)
      else $error("connection state out of range");

   // A request is taken from the queue only when the engine is idle.
   a_pop_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && q_valid))
      else $error("queue popped while engine busy");

   // A finished result reaches the output register in the cycle after it is released.
   a_done_out : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result lost on release");

endmodule

// File: src/reliable_link_ack_tracker_top.sv
// Top level of the reliable link acknowledgement tracker.
//
// Requests arrive on the req_ stream: tuser carries the action (open, send,
// receive, tick) and tdata the peer address, header fields and elapsed time.
// Each request yields exactly one response on the rsp_ stream with the
// outgoing header, the number of retired pending entries, the accepted and
// table-full flags and the link state after the request.
// Two configuration registers (role, timeout in ms) are written on the csr_
// port; the user must write them only while the block is idle, as the block
// itself does not enforce it. A two-entry request queue sits in front of the
// engine, so requests are taken while the engine works or a response waits.
// Open and tick go straight to the done state; a send first runs the
// one-entry-per-cycle free slot search, and a receive first runs the retire
// scan that reads the pending table through one memory port. The engine
// works on one request at a time, so it takes a new one from the queue only
// after the previous response has entered the output register.
// Reset clears the link, sequences, history and all pending entries at
// once; no clearing pass is needed. A stalled response holds in the output
// register and the engine waits behind it while the queue fills.
module reliable_link_ack_tracker_top #(
   parameter int PENDING_DEPTH = rlat_pkg::PENDING_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [15:0]                      csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: peer_address, sequence_req, ack, ack_mask, elapsed_ms.
   input  logic [rlat_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Fields from bit 0 up: action.
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0 up: hdr_sequence, hdr_ack, hdr_ack_bits, acked_count,
   // accepted, table_full, link_state.
   output logic [rlat_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic               q_valid;
   logic               q_pop;
   rlat_pkg::item_type q_item;

   rlat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   rlat_back #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the reliable link acknowledgement tracker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = rlat_pkg::PENDING_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [rlat_pkg::PEER_W-1:0] PEER_A = 48'hC0A8_0001_1F90;
   localparam logic [rlat_pkg::PEER_W-1:0] PEER_B = 48'h0A00_0002_D431;

   typedef enum logic [1:0] {MODE_NONE, MODE_SERVER, MODE_CLIENT} link_mode_type;

   // One response as seen on the rsp_ stream.
   typedef struct {
      logic [rlat_pkg::SEQ_W-1:0]   hseq;
      logic [rlat_pkg::SEQ_W-1:0]   hack;
      logic [rlat_pkg::BITS_W-1:0]  hbits;
      logic [rlat_pkg::COUNT_W-1:0] acked;
      logic                         acc;
      logic                         full;
      logic [rlat_pkg::STATE_W-1:0] st;
   } link_rsp_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic                            csr_index;
   logic [15:0]                     csr_wdata;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [rlat_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                      req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [rlat_pkg::RSP_DATA_W-1:0] rsp_tdata;

   reliable_link_ack_tracker_top uut (.*);

   // Shadow copy of the link state and configuration.
   logic [rlat_pkg::STATE_W-1:0] lk_state;
   int unsigned                  lk_silence;
   logic [rlat_pkg::PEER_W-1:0]  lk_peer;
   logic [rlat_pkg::SEQ_W-1:0]   lk_lseq;
   logic [rlat_pkg::SEQ_W-1:0]   lk_rseq;
   logic                         lk_seen;
   logic [rlat_pkg::BITS_W-1:0]  lk_hist;
   logic [rlat_pkg::SEQ_W-1:0]   pend_sq [DEPTH];
   logic                         pend_ok [DEPTH];
   link_mode_type                lk_mode;
   logic                         cfg_role;
   logic [15:0]                  cfg_timeout;

   link_rsp_type link_rsp_q[$];
   int  errors;
   int  cycles;
   int  gap_max;
   bit  rsp_stall_on;
   int  rsp_hold;
   int  kind_count [4];
   int  rsp_checked;
   int  full_seen;
   int  acked_total;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic bit seq_is_newer(logic [rlat_pkg::SEQ_W-1:0] a,
                                       logic [rlat_pkg::SEQ_W-1:0] b);
      logic [rlat_pkg::SEQ_W-1:0] d;
      d = a - b;
      return d != 0 && d < 16'h8000;
   endfunction

   // Advance the shadow state by one request and return the expected response.
   function automatic link_rsp_type link_predict(rlat_pkg::kind_type k,
         logic [rlat_pkg::PEER_W-1:0] peer, logic [rlat_pkg::SEQ_W-1:0] seq,
         logic [rlat_pkg::SEQ_W-1:0] ack, logic [rlat_pkg::BITS_W-1:0] bits,
         logic [rlat_pkg::MS_W-1:0] el);
      link_rsp_type r;
      logic [rlat_pkg::SEQ_W-1:0] d;
      logic [rlat_pkg::SEQ_W-1:0] bi;
      int slot;
      bit hit;
      r = '{default: '0};
      case (k)
         rlat_pkg::KIND_OPEN: begin
            lk_silence = 0;
            lk_peer = '0;
            if (cfg_role == rlat_pkg::ROLE_SERVER) begin
               lk_mode = MODE_SERVER;
               lk_state = rlat_pkg::LINK_LISTENING;
            end else begin
               lk_mode = MODE_CLIENT;
               lk_state = rlat_pkg::LINK_CONNECTING;
               lk_peer = peer;
            end
         end
         rlat_pkg::KIND_SEND: begin
            r.hseq = lk_lseq;
            r.hack = lk_rseq;
            r.hbits = lk_hist;
            slot = -1;
            for (int i = 0; i < DEPTH && slot < 0; i++)
               if (!pend_ok[i]) slot = i;
            if (slot < 0) begin
               r.full = 1'b1;
            end else begin
               pend_sq[slot] = lk_lseq;
               pend_ok[slot] = 1'b1;
            end
            lk_lseq = lk_lseq + 1'b1;
         end
         rlat_pkg::KIND_RECV: begin
            // Update the received history.
            if (!lk_seen) begin
               lk_seen = 1'b1;
               lk_rseq = seq;
               lk_hist = '0;
            end else if (seq_is_newer(seq, lk_rseq)) begin
               d = seq - lk_rseq;
               if (d < 32) lk_hist = (lk_hist << d) | (32'd1 << (d - 1));
               else if (d == 32) lk_hist = 32'h8000_0000;
               else lk_hist = '0;
               lk_rseq = seq;
            end else if (seq != lk_rseq) begin
               d = lk_rseq - seq;
               if (d - 1 <= rlat_pkg::HISTORY_TOP) lk_hist |= 32'd1 << (d - 1);
            end
            // Retire acknowledged pending sends.
            for (int i = 0; i < DEPTH; i++) begin
               if (pend_ok[i]) begin
                  hit = 0;
                  if (pend_sq[i] == ack) begin
                     hit = 1;
                  end else if (!seq_is_newer(pend_sq[i], ack)) begin
                     bi = ack - pend_sq[i] - 1'b1;
                     if (bi <= rlat_pkg::HISTORY_TOP) hit = bits[bi[4:0]];
                  end
                  if (hit) begin
                     pend_ok[i] = 1'b0;
                     if (r.acked != rlat_pkg::COUNT_MAX) r.acked++;
                  end
               end
            end
            if (lk_mode == MODE_SERVER && lk_state != rlat_pkg::LINK_CONNECTED) begin
               lk_state = rlat_pkg::LINK_CONNECTED;
               lk_peer = peer;
            end
            if (peer == lk_peer) begin
               if (lk_mode == MODE_CLIENT && lk_state == rlat_pkg::LINK_CONNECTING)
                  lk_state = rlat_pkg::LINK_CONNECTED;
               lk_silence = 0;
               r.acc = 1'b1;
            end
         end
         default: begin
            lk_silence += 32'(el);
            if (lk_silence > rlat_pkg::SILENCE_MAX) lk_silence = 32'(rlat_pkg::SILENCE_MAX);
            if (lk_silence > cfg_timeout) begin
               if (lk_state == rlat_pkg::LINK_CONNECTING) begin
                  lk_silence = 0;
                  lk_peer = '0;
                  lk_state = rlat_pkg::LINK_CONNECT_FAIL;
               end else if (lk_state == rlat_pkg::LINK_CONNECTED) begin
                  lk_silence = 0;
                  lk_peer = '0;
                  lk_state = rlat_pkg::LINK_DISCONNECTED;
               end
            end
         end
      endcase
      r.st = lk_state;
      return r;
   endfunction

   // Offer one request, wait for its handshake, then record its expected response.
   task automatic push_request(rlat_pkg::kind_type k, logic [rlat_pkg::PEER_W-1:0] peer,
         logic [rlat_pkg::SEQ_W-1:0] seq, logic [rlat_pkg::SEQ_W-1:0] ack,
         logic [rlat_pkg::BITS_W-1:0] bits, logic [rlat_pkg::MS_W-1:0] el);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {el, bits, ack, seq, peer};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      link_rsp_q.insert(link_rsp_q.size(), link_predict(k, peer, seq, ack, bits, el));
      kind_count[k]++;
   endtask

   // Stop offering and wait until every expected response has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (link_rsp_q.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rlat_pkg::CSR_ROLE) cfg_role = val[0];
      else cfg_timeout = val;
   endtask

   function automatic logic [rlat_pkg::PEER_W-1:0] rand_peer();
      return 48'({$urandom, $urandom});
   endfunction

   // One random request: mostly a plausible packet exchange, some noise.
   task automatic rand_request();
      int pick;
      logic [rlat_pkg::PEER_W-1:0] peer;
      logic [rlat_pkg::SEQ_W-1:0] seq;
      pick = $urandom_range(0, 99);
      peer = ($urandom_range(0, 9) < 8) ? ((lk_peer != 0) ? lk_peer : PEER_A)
           : (($urandom_range(0, 1) != 0) ? PEER_B : rand_peer());
      if (pick < 4) begin
         push_request(rlat_pkg::KIND_OPEN, peer, 16'($urandom), 16'($urandom), $urandom,
                      16'($urandom));
      end else if (pick < 40) begin
         push_request(rlat_pkg::KIND_SEND, rand_peer(), 16'($urandom), 16'($urandom),
                      $urandom, 16'($urandom));
      end else if (pick < 82) begin
         case ($urandom_range(0, 9))
            0: seq = lk_rseq - 16'($urandom_range(0, 40));
            1: seq = 16'($urandom);
            default: seq = lk_rseq + 16'($urandom_range(1, 3));
         endcase
         push_request(rlat_pkg::KIND_RECV, peer, seq, lk_lseq - 16'($urandom_range(1, 8)),
                      ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom,
                      16'($urandom));
      end else if (pick < 95) begin
         push_request(rlat_pkg::KIND_TICK, rand_peer(), 16'($urandom), 16'($urandom),
                      $urandom,
                      ($urandom_range(0, 9) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, cfg_timeout / 3 + 1)));
      end else begin
         push_request(rlat_pkg::kind_type'($urandom_range(0, 3)), rand_peer(),
                      16'($urandom), 16'($urandom), $urandom, 16'($urandom));
      end
   endtask

   // Response ready with random stalls and a long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_tready && rsp_tvalid) begin
            stall_left = rsp_stall_on ? $urandom_range(0, 19) : 0;
            if (stall_left > 0) rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
      end
   endfunction

   // Compare each response with the oldest expectation.
   always @(posedge clock) begin
      link_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (link_rsp_q.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, actual %0h", $time, rsp_tdata);
         end else begin
            e = link_rsp_q[0];
            link_rsp_q.delete(0);
            rsp_checked++;
            if (e.full) full_seen++;
            acked_total += e.acked;
            check_field("hdr_sequence", 32'(e.hseq), 32'(rsp_tdata[15:0]));
            check_field("hdr_ack", 32'(e.hack), 32'(rsp_tdata[31:16]));
            check_field("hdr_ack_bits", e.hbits, rsp_tdata[63:32]);
            check_field("acked_count", 32'(e.acked), 32'(rsp_tdata[69:64]));
            check_field("accepted", 32'(e.acc), 32'(rsp_tdata[70]));
            check_field("table_full", 32'(e.full), 32'(rsp_tdata[71]));
            check_field("link_state", 32'(e.st), 32'(rsp_tdata[74:72]));
            check_field("padding", 32'd0, 32'(rsp_tdata[79:75]));
         end
      end
   end

   // Receive before any open, server connect, history edges, foreign peer, timeout.
   task automatic test_server_basics();
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'd5, 16'd0, 32'd0, 16'd0);
      push_request(rlat_pkg::KIND_OPEN, '1, '1, '1, '1, '1);
      push_request(rlat_pkg::KIND_SEND, '0, '0, '0, '0, '0);
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'hFFFF, 16'd0, 32'd0, 16'hFFFF);
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'd40, 16'd0, 32'd0, 16'd0);
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'd72, 16'd0, 32'd0, 16'd0);
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'd72, 16'd0, 32'd0, 16'd0);
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'd40, 16'd0, 32'd0, 16'd0);
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'd39, 16'd0, 32'd0, 16'd0);
      push_request(rlat_pkg::KIND_RECV, PEER_B, 16'd73, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
      repeat (3) push_request(rlat_pkg::KIND_SEND, '1, '1, '1, '1, '1);
      push_request(rlat_pkg::KIND_RECV, PEER_A, 16'd74, lk_lseq - 1'b1, 32'hFFFF_FFFF,
                   16'd0);
      push_request(rlat_pkg::KIND_TICK, '0, '0, '0, '0, 16'd0);
      push_request(rlat_pkg::KIND_TICK, '0, '0, '0, '0, 16'hFFFF);
      push_request(rlat_pkg::KIND_RECV, PEER_B, 16'd75, 16'd0, 32'd0, 16'd0);
   endtask

   // Client connect, connect failure, foreign peer while connecting, tight timeout.
   task automatic test_client_link();
      push_request(rlat_pkg::KIND_OPEN, PEER_A, '0, '0, '0, '0);
      push_request(rlat_pkg::KIND_TICK, '0, '0, '0, '0, 16'd2);
      push_request(rlat_pkg::KIND_OPEN, PEER_A, '0, '0, '0, '0);
      push_request(rlat_pkg::KIND_RECV, PEER_B, lk_rseq + 1'b1, '0, '0, '0);
      push_request(rlat_pkg::KIND_RECV, PEER_A, lk_rseq + 1'b1, '0, '0, '0);
      push_request(rlat_pkg::KIND_TICK, '0, '0, '0, '0, 16'd1);
      push_request(rlat_pkg::KIND_TICK, '0, '0, '0, '0, 16'd1);
   endtask

   // Silence saturates while listening, then a receive connects.
   task automatic test_silence_saturation();
      push_request(rlat_pkg::KIND_OPEN, '0, '0, '0, '0, '0);
      repeat (3) push_request(rlat_pkg::KIND_TICK, '0, '0, '0, '0, 16'hFFFF);
      push_request(rlat_pkg::KIND_RECV, PEER_A, lk_rseq + 1'b1, '0, '0, '0);
      push_request(rlat_pkg::KIND_TICK, '0, '0, '0, '0, 16'hFFFF);
   endtask

   // Fill the pending table past its end, then retire all entries but the oldest at once.
   task automatic test_table_full();
      repeat (DEPTH + 2) push_request(rlat_pkg::KIND_SEND, rand_peer(), '0, '0, '0, '0);
      push_request(rlat_pkg::KIND_RECV, PEER_A, lk_rseq + 1'b1, lk_lseq - 1'b1,
                   32'hFFFF_FFFF, '0);
      push_request(rlat_pkg::KIND_SEND, rand_peer(), '0, '0, '0, '0);
   endtask

   // Hold the response side off long enough that the input stalls.
   task automatic test_backpressure();
      gap_max = 0;
      rsp_hold = 300;
      repeat (16) rand_request();
      wait_drained();
      gap_max = 19;
   endtask

   // Random traffic under one configuration; the first stretch runs without idling.
   task automatic test_random_phase(logic role, logic [15:0] tmo, int n);
      wait_drained();
      csr_write(rlat_pkg::CSR_ROLE, {15'd0, role});
      csr_write(rlat_pkg::CSR_TIMEOUT, tmo);
      push_request(rlat_pkg::KIND_OPEN, PEER_A, '0, '0, '0, '0);
      gap_max = 0;
      rsp_stall_on = 0;
      for (int i = 0; i < n; i++) begin
         if (i == 60) begin
            gap_max = 19;
            rsp_stall_on = 1;
         end
         rand_request();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= rlat_pkg::CSR_ROLE;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= rlat_pkg::KIND_OPEN;
      lk_state = rlat_pkg::LINK_DISCONNECTED;
      lk_silence = 0;
      lk_peer = '0;
      lk_lseq = '0;
      lk_rseq = '0;
      lk_seen = 1'b0;
      lk_hist = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pend_sq[i] = '0;
         pend_ok[i] = 1'b0;
      end
      lk_mode = MODE_NONE;
      cfg_role = rlat_pkg::ROLE_SERVER;
      cfg_timeout = rlat_pkg::TIMEOUT_RESET;
      gap_max = 19;
      rsp_stall_on = 1;
      rsp_hold = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_server_basics();
      wait_drained();
      csr_write(rlat_pkg::CSR_ROLE, 16'd1);
      csr_write(rlat_pkg::CSR_TIMEOUT, 16'd1);
      test_client_link();
      wait_drained();
      csr_write(rlat_pkg::CSR_ROLE, 16'd0);
      csr_write(rlat_pkg::CSR_TIMEOUT, 16'hFFFF);
      test_silence_saturation();
      test_table_full();
      test_backpressure();
      test_random_phase(1'b0, 16'd10000, 300);
      test_random_phase(1'b1, 16'd500, 300);
      test_random_phase(1'b0, 16'd1, 300);
      test_random_phase(1'b1, 16'hFFFF, 300);
      wait_drained();

      $display("Requests: %0d open, %0d send, %0d receive, %0d tick; %0d responses checked.",
               kind_count[rlat_pkg::KIND_OPEN], kind_count[rlat_pkg::KIND_SEND],
               kind_count[rlat_pkg::KIND_RECV], kind_count[rlat_pkg::KIND_TICK],
               rsp_checked);
      $display("Full-table sends: %0d, pending entries retired: %0d, errors: %0d.",
               full_seen, acked_total, errors);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
